// File: src/tsag_pkg.sv
package tsag_pkg;

    localparam int COORD_BITS_DEFAULT  = 14;
    localparam int STRIDE_BITS_DEFAULT = 20;
    localparam int OFFSET_BITS_DEFAULT = 36;

    localparam int BPP_BITS    = 5;
    localparam int CFG_IDX_BITS = 2;

    // Reset value of bytes_per_pixel.
    localparam logic [BPP_BITS-1:0] BPP_RESET = BPP_BITS'(4);

    typedef enum logic [2:0] {
        LAYOUT_LINEAR          = 3'd0,
        LAYOUT_MINOR_2X2       = 3'd1,
        LAYOUT_TILED           = 3'd2,
        LAYOUT_SPLIT_TILED     = 3'd3,
        LAYOUT_SPLIT_SUPERTILE = 3'd4,
        LAYOUT_SUPERTILE       = 3'd5
    } layout_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROW_STRIDE     = 2'd0,
        REG_BYTES_PER_PIX  = 2'd1,
        REG_LAYOUT_MODE    = 2'd2,
        REG_NEW_ORDER      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [BPP_BITS-1:0] bytes_per_pixel;
        logic [2:0]          layout_mode;
        logic                new_supertile_order;
    } surf_cfg_t;

endpackage

// File: src/tsag_ifs.sv
interface tsag_pixel_if #(
    parameter int COORD_BITS = tsag_pkg::COORD_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface tsag_addr_if #(
    parameter int OFFSET_BITS = tsag_pkg::OFFSET_BITS_DEFAULT
);
    logic                   valid;
    logic                   ready;
    logic                   plane_index;
    logic [OFFSET_BITS-1:0] byte_offset;

    modport source (output valid, output plane_index, output byte_offset, input ready);
    modport sink   (input valid, input plane_index, input byte_offset, output ready);
endinterface

interface tsag_cfg_if #(
    parameter int DATA_BITS = tsag_pkg::STRIDE_BITS_DEFAULT
);
    logic                              valid;
    logic                              ready;
    logic [tsag_pkg::CFG_IDX_BITS-1:0] index;
    logic [DATA_BITS-1:0]              data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/tsag_cfg_regs.sv
module tsag_cfg_regs #(
    parameter int STRIDE_BITS = tsag_pkg::STRIDE_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_valid,
    input  logic [tsag_pkg::CFG_IDX_BITS-1:0] wr_index,
    input  logic [STRIDE_BITS-1:0]            wr_data,
    output logic [STRIDE_BITS-1:0]            row_stride,
    output tsag_pkg::surf_cfg_t               surf_cfg
);

    logic [STRIDE_BITS-1:0] stride_reg;
    logic [STRIDE_BITS-1:0] stride_next;
    tsag_pkg::surf_cfg_t    cfg_reg;
    tsag_pkg::surf_cfg_t    cfg_next;

    always_comb
    begin
        stride_next = stride_reg;
        cfg_next    = cfg_reg;
        if (wr_valid)
        begin
            unique case (tsag_pkg::cfg_index_t'(wr_index))
                tsag_pkg::REG_ROW_STRIDE:
                    stride_next = wr_data;
                tsag_pkg::REG_BYTES_PER_PIX:
                    cfg_next.bytes_per_pixel = wr_data[tsag_pkg::BPP_BITS-1:0];
                tsag_pkg::REG_LAYOUT_MODE:
                    cfg_next.layout_mode = wr_data[2:0];
                tsag_pkg::REG_NEW_ORDER:
                    cfg_next.new_supertile_order = wr_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg                  <= '0;
            cfg_reg.bytes_per_pixel     <= tsag_pkg::BPP_RESET;
            cfg_reg.layout_mode         <= tsag_pkg::LAYOUT_LINEAR;
            cfg_reg.new_supertile_order <= 1'b0;
        end
        else
        begin
            stride_reg <= stride_next;
            cfg_reg    <= cfg_next;
        end
    end

    assign row_stride = stride_reg;
    assign surf_cfg   = cfg_reg;

endmodule

// File: src/tsag_decode.sv
module tsag_decode #(
    parameter int COORD_BITS = tsag_pkg::COORD_BITS_DEFAULT,
    parameter int UNIT_BITS  = COORD_BITS + 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tsag_pkg::surf_cfg_t   surf_cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] row_units,
    output logic [UNIT_BITS-1:0]  pix_units,
    output logic                  plane
);

    logic                  valid_reg;
    logic [COORD_BITS-1:0] row_reg;
    logic [UNIT_BITS-1:0]  units_reg;
    logic                  plane_reg;
    logic [COORD_BITS-1:0] row_next;
    logic [UNIT_BITS-1:0]  units_next;
    logic                  plane_next;
    logic [3:0]            pix_idx;
    logic [3:0]            lx;
    logic [4:0]            ly;
    logic [7:0]            num;

    // Every layout reduces to row_units * stride + pix_units * bytes_per_pixel.
    always_comb
    begin
        pix_idx    = {pixel_y[1:0], pixel_x[1:0]};
        lx         = pixel_x[5:2];
        ly         = pixel_y[6:2];
        num        = '0;
        plane_next = 1'b0;
        row_next   = '0;
        units_next = '0;
        unique case (surf_cfg.layout_mode)
            tsag_pkg::LAYOUT_LINEAR:
            begin
                row_next   = pixel_y;
                units_next = UNIT_BITS'(pixel_x);
            end
            tsag_pkg::LAYOUT_MINOR_2X2:
            begin
                row_next   = pixel_y >> 1;
                units_next = UNIT_BITS'({pixel_x[COORD_BITS-1:1], pixel_y[0], pixel_x[0]});
            end
            tsag_pkg::LAYOUT_TILED:
            begin
                row_next   = pixel_y >> 2;
                units_next = UNIT_BITS'({pixel_x[COORD_BITS-1:2], pix_idx});
            end
            tsag_pkg::LAYOUT_SPLIT_TILED:
            begin
                // Odd tile rows swap into the odd tile column of the other plane.
                row_next   = pixel_y >> 3;
                units_next = UNIT_BITS'({pixel_x[COORD_BITS-1:3], pixel_y[2], pix_idx});
                plane_next = pixel_x[2] ^ pixel_y[2];
            end
            tsag_pkg::LAYOUT_SPLIT_SUPERTILE:
            begin
                num        = {ly[4], ly[3], lx[3], lx[2], ly[0], ly[2], ly[1], lx[0]};
                plane_next = lx[1] ^ ly[0];
                row_next   = COORD_BITS'(pixel_y >> 7) << 4;
                units_next = (UNIT_BITS'(pixel_x >> 6) << 12) | UNIT_BITS'({num, pix_idx});
            end
            default:
            begin
                // Single-pipe supertile; the unused codes decode the same way.
                if (surf_cfg.new_supertile_order)
                    num = {ly[3], lx[3], ly[2], lx[2], ly[1], lx[1], ly[0], lx[0]};
                else
                    num = {ly[3:2], lx[3:1], ly[1:0], lx[0]};
                row_next   = COORD_BITS'(pixel_y >> 6) << 4;
                units_next = (UNIT_BITS'(pixel_x >> 6) << 12) | UNIT_BITS'({num, pix_idx});
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            row_reg   <= row_next;
            units_reg <= units_next;
            plane_reg <= plane_next;
        end
    end

    assign out_valid = valid_reg;
    assign row_units = row_reg;
    assign pix_units = units_reg;
    assign plane     = plane_reg;

endmodule

// File: src/tsag_mult.sv
module tsag_mult #(
    parameter int COORD_BITS  = tsag_pkg::COORD_BITS_DEFAULT,
    parameter int STRIDE_BITS = tsag_pkg::STRIDE_BITS_DEFAULT,
    parameter int UNIT_BITS   = COORD_BITS + 6,
    parameter int ROWP_BITS   = COORD_BITS + STRIDE_BITS,
    parameter int PIXP_BITS   = UNIT_BITS + tsag_pkg::BPP_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [STRIDE_BITS-1:0] row_stride,
    input  tsag_pkg::surf_cfg_t    surf_cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_BITS-1:0]  row_units,
    input  logic [UNIT_BITS-1:0]   pix_units,
    input  logic                   plane_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ROWP_BITS-1:0]   row_prod,
    output logic [PIXP_BITS-1:0]   pix_prod,
    output logic                   plane_out
);

    logic                 valid_reg;
    logic [ROWP_BITS-1:0] row_reg;
    logic [PIXP_BITS-1:0] pix_reg;
    logic                 plane_reg;
    logic [ROWP_BITS-1:0] row_next;
    logic [PIXP_BITS-1:0] pix_next;

    always_comb
    begin
        row_next = ROWP_BITS'(row_units) * ROWP_BITS'(row_stride);
        pix_next = PIXP_BITS'(pix_units) * PIXP_BITS'(surf_cfg.bytes_per_pixel);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            row_reg   <= row_next;
            pix_reg   <= pix_next;
            plane_reg <= plane_in;
        end
    end

    assign out_valid = valid_reg;
    assign row_prod  = row_reg;
    assign pix_prod  = pix_reg;
    assign plane_out = plane_reg;

endmodule

// File: src/tsag_sum.sv
module tsag_sum #(
    parameter int ROWP_BITS   = tsag_pkg::COORD_BITS_DEFAULT + tsag_pkg::STRIDE_BITS_DEFAULT,
    parameter int PIXP_BITS   = tsag_pkg::COORD_BITS_DEFAULT + 6 + tsag_pkg::BPP_BITS,
    parameter int OFFSET_BITS = tsag_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ROWP_BITS-1:0]   row_prod,
    input  logic [PIXP_BITS-1:0]   pix_prod,
    input  logic                   plane_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OFFSET_BITS-1:0] byte_offset,
    output logic                   plane_index
);

    logic                   valid_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   plane_reg;
    logic [OFFSET_BITS-1:0] offset_next;

    // The offset wraps at the output width.
    always_comb
    begin
        offset_next = OFFSET_BITS'(row_prod) + OFFSET_BITS'(pix_prod);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            offset_reg <= offset_next;
            plane_reg  <= plane_in;
        end
    end

    assign out_valid   = valid_reg;
    assign byte_offset = offset_reg;
    assign plane_index = plane_reg;

endmodule

// File: src/tiled_surface_address_gen.sv
// Pipeline: each request passes through the decode, multiply and add stages, each registered.
// Throughput: one request per cycle while address.ready stays high; each stage holds only
// while the stage after it is full and stalled, so bubbles close up and nothing is lost
// or repeated.
// Reset: rst_n clears all stage valid bits and loads the register defaults
// (stride 0, 4 bytes per pixel, linear layout, old supertile order).
module tiled_surface_address_gen #(
    parameter int COORD_BITS  = tsag_pkg::COORD_BITS_DEFAULT,
    parameter int STRIDE_BITS = tsag_pkg::STRIDE_BITS_DEFAULT,
    parameter int OFFSET_BITS = tsag_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    tsag_pixel_if.sink        pixel,
    tsag_addr_if.source       address,
    tsag_cfg_if.sink          cfg
);

    localparam int UNIT_BITS = COORD_BITS + 6;
    localparam int ROWP_BITS = COORD_BITS + STRIDE_BITS;
    localparam int PIXP_BITS = UNIT_BITS + tsag_pkg::BPP_BITS;

    logic [STRIDE_BITS-1:0] row_stride;
    tsag_pkg::surf_cfg_t    surf_cfg;

    logic                   dec_valid;
    logic                   dec_ready;
    logic [COORD_BITS-1:0]  dec_row;
    logic [UNIT_BITS-1:0]   dec_units;
    logic                   dec_plane;

    logic                   mul_valid;
    logic                   mul_ready;
    logic [ROWP_BITS-1:0]   mul_row;
    logic [PIXP_BITS-1:0]   mul_pix;
    logic                   mul_plane;

    assign cfg.ready = 1'b1;

    tsag_cfg_regs #(
        .STRIDE_BITS (STRIDE_BITS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_valid   (cfg.valid),
        .wr_index   (cfg.index),
        .wr_data    (cfg.data),
        .row_stride (row_stride),
        .surf_cfg   (surf_cfg)
    );

    tsag_decode #(
        .COORD_BITS (COORD_BITS),
        .UNIT_BITS  (UNIT_BITS)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .surf_cfg  (surf_cfg),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .pixel_x   (pixel.pixel_x),
        .pixel_y   (pixel.pixel_y),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .row_units (dec_row),
        .pix_units (dec_units),
        .plane     (dec_plane)
    );

    tsag_mult #(
        .COORD_BITS  (COORD_BITS),
        .STRIDE_BITS (STRIDE_BITS),
        .UNIT_BITS   (UNIT_BITS),
        .ROWP_BITS   (ROWP_BITS),
        .PIXP_BITS   (PIXP_BITS)
    ) u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_stride (row_stride),
        .surf_cfg   (surf_cfg),
        .in_valid   (dec_valid),
        .in_ready   (dec_ready),
        .row_units  (dec_row),
        .pix_units  (dec_units),
        .plane_in   (dec_plane),
        .out_valid  (mul_valid),
        .out_ready  (mul_ready),
        .row_prod   (mul_row),
        .pix_prod   (mul_pix),
        .plane_out  (mul_plane)
    );

    tsag_sum #(
        .ROWP_BITS   (ROWP_BITS),
        .PIXP_BITS   (PIXP_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_sum (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (mul_valid),
        .in_ready    (mul_ready),
        .row_prod    (mul_row),
        .pix_prod    (mul_pix),
        .plane_in    (mul_plane),
        .out_valid   (address.valid),
        .out_ready   (address.ready),
        .byte_offset (address.byte_offset),
        .plane_index (address.plane_index)
    );

endmodule

// File: tb/tiled_surface_address_gen_tb.sv
`timescale 1ns / 1ps

localparam int TB_COORD_BITS  = tsag_pkg::COORD_BITS_DEFAULT;
localparam int TB_STRIDE_BITS = tsag_pkg::STRIDE_BITS_DEFAULT;
localparam int TB_OFFSET_BITS = tsag_pkg::OFFSET_BITS_DEFAULT;
localparam int TB_BPP_BITS    = tsag_pkg::BPP_BITS;

typedef struct {
    logic                      plane_index;
    logic [TB_OFFSET_BITS-1:0] byte_offset;
} pixel_address_t;

// Keeps a copy of the surface registers and the addresses still owed by the block.
class pixel_address_tracker;
    logic [TB_STRIDE_BITS-1:0] row_stride;
    logic [TB_BPP_BITS-1:0]    bytes_per_pixel;
    logic [2:0]                layout_mode;
    logic                      new_order;
    pixel_address_t            owed_addresses[$];
    int                        errors;

    function new();
        row_stride      = '0;
        bytes_per_pixel = tsag_pkg::BPP_RESET;
        layout_mode     = tsag_pkg::LAYOUT_LINEAR;
        new_order       = 1'b0;
        errors          = 0;
    endfunction

    function void write_register(logic [tsag_pkg::CFG_IDX_BITS-1:0] idx,
                                 logic [TB_STRIDE_BITS-1:0] data);
        case (idx)
            tsag_pkg::REG_ROW_STRIDE:    row_stride      = data;
            tsag_pkg::REG_BYTES_PER_PIX: bytes_per_pixel = data[TB_BPP_BITS-1:0];
            tsag_pkg::REG_LAYOUT_MODE:   layout_mode     = data[2:0];
            tsag_pkg::REG_NEW_ORDER:     new_order       = data[0];
            default:                     ;
        endcase
    endfunction

    function pixel_address_t locate_pixel(logic [TB_COORD_BITS-1:0] x,
                                          logic [TB_COORD_BITS-1:0] y);
        pixel_address_t r;
        logic [63:0]    xs, ys, st, bp, tile, tx, ty, pix, ltx, lx, ly, num, o;
        logic           p;
        xs = 64'(x);
        ys = 64'(y);
        st = 64'(row_stride);
        bp = 64'(bytes_per_pixel);
        p  = 1'b0;
        if (layout_mode == tsag_pkg::LAYOUT_LINEAR)
        begin
            o = ys * st + xs * bp;
        end
        else if (layout_mode == tsag_pkg::LAYOUT_MINOR_2X2)
        begin
            o = (ys >> 1) * st + (xs >> 1) * (4 * bp) + 64'({ys[0], xs[0]}) * bp;
        end
        else
        begin
            tile = 16 * bp;
            tx   = xs >> 2;
            ty   = ys >> 2;
            pix  = 64'({ys[1:0], xs[1:0]}) * bp;
            if (layout_mode == tsag_pkg::LAYOUT_TILED)
            begin
                o = ty * st + tx * tile + pix;
            end
            else if (layout_mode == tsag_pkg::LAYOUT_SPLIT_TILED)
            begin
                // Odd tile rows borrow the low column bit, the plane alternates like a checkerboard.
                ltx = {tx[63:1], ty[0]};
                p   = tx[0] ^ ty[0];
                o   = (ty >> 1) * st + ltx * tile + pix;
            end
            else if (layout_mode == tsag_pkg::LAYOUT_SPLIT_SUPERTILE)
            begin
                lx  = tx & 15;
                ly  = ty & 31;
                num = ((ly & 24) << 3) + ((lx >> 2) << 4) + ((ly & 1) << 3) + (ly & 6)
                      + (lx & 1);
                p   = lx[1] ^ ly[0];
                o   = (ty >> 5) * 16 * st + (tx >> 4) * 256 * tile + num * tile + pix;
            end
            else
            begin
                // Single-pipe supertile; the two unassigned codes decode here as well.
                lx = tx & 15;
                ly = ty & 15;
                if (new_order)
                    num = 64'({ly[3], lx[3], ly[2], lx[2], ly[1], lx[1], ly[0], lx[0]});
                else
                    num = (ly >> 2) * 64 + (lx >> 1) * 8 + (ly & 3) * 2 + (lx & 1);
                o = (ty >> 4) * 16 * st + (tx >> 4) * 256 * tile + num * tile + pix;
            end
        end
        r.plane_index = p;
        r.byte_offset = o[TB_OFFSET_BITS-1:0];
        return r;
    endfunction

    function void note_pixel(logic [TB_COORD_BITS-1:0] x, logic [TB_COORD_BITS-1:0] y);
        owed_addresses.push_back(locate_pixel(x, y));
    endfunction

    function void check_address(logic plane, logic [TB_OFFSET_BITS-1:0] offset);
        pixel_address_t e;
        if (owed_addresses.size() == 0)
        begin
            $error("address with no pixel request waiting: plane_index %0d, byte_offset %0d",
                   plane, offset);
            errors++;
            return;
        end
        e = owed_addresses.pop_front();
        if (plane !== e.plane_index)
        begin
            $error("plane_index mismatch: expected %0d, actual %0d", e.plane_index, plane);
            errors++;
        end
        if (offset !== e.byte_offset)
        begin
            $error("byte_offset mismatch: expected %0d, actual %0d", e.byte_offset, offset);
            errors++;
        end
    endfunction

    function int owed();
        return owed_addresses.size();
    endfunction
endclass

module tiled_surface_address_gen_tb;

    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_CYCLES      = 400;
    localparam int STALL_LIMIT      = 4000;
    localparam int RANDOM_PHASES    = 18;
    localparam int ITEMS_PER_PHASE  = 50;
    localparam int PRESSURE_PHASE   = 14;
    localparam logic [TB_COORD_BITS-1:0]  COORD_MAX  = '1;
    localparam logic [TB_STRIDE_BITS-1:0] STRIDE_MAX = '1;
    // Unassigned layout codes, which decode as the single-pipe supertile.
    localparam logic [2:0] LAYOUT_SPARE_A = 3'd6;
    localparam logic [2:0] LAYOUT_SPARE_B = 3'd7;

    logic clk;
    logic rst_n;

    tsag_pixel_if pixel_ch ();
    tsag_addr_if  address_ch ();
    tsag_cfg_if   cfg_ch ();

    tiled_surface_address_gen u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pixel_ch),
        .address (address_ch),
        .cfg     (cfg_ch)
    );

    pixel_address_tracker tracker = new();

    int unsigned sender_idle_pct   = 33;
    int unsigned receiver_idle_pct = 73;
    bit          hold_request      = 1'b0;
    int          stall_count       = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Receiver side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        address_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                address_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                address_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // Inputs are noted before outputs are checked, so the queue order holds at any latency.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                tracker.write_register(cfg_ch.index, cfg_ch.data);
            if (pixel_ch.valid && pixel_ch.ready)
                tracker.note_pixel(pixel_ch.pixel_x, pixel_ch.pixel_y);
            if (address_ch.valid && address_ch.ready)
                tracker.check_address(address_ch.plane_index, address_ch.byte_offset);
            if ((cfg_ch.valid && cfg_ch.ready) || (pixel_ch.valid && pixel_ch.ready)
                || (address_ch.valid && address_ch.ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_pixel(input logic [TB_COORD_BITS-1:0] x,
                              input logic [TB_COORD_BITS-1:0] y);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid   <= 1'b1;
        pixel_ch.pixel_x <= x;
        pixel_ch.pixel_y <= y;
        @(posedge clk);
        while (!pixel_ch.ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        pixel_ch.valid <= 1'b0;
        do @(posedge clk); while (tracker.owed() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input tsag_pkg::cfg_index_t idx,
                             input logic [TB_STRIDE_BITS-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    // Unused upper data bits are randomized; the block must drop them.
    task automatic set_surface(input logic [TB_STRIDE_BITS-1:0] stride,
                               input logic [TB_BPP_BITS-1:0] bpp,
                               input logic [2:0] layout,
                               input logic order);
        wait_drained();
        cfg_write(tsag_pkg::REG_ROW_STRIDE, stride);
        cfg_write(tsag_pkg::REG_BYTES_PER_PIX, {15'($urandom), bpp});
        cfg_write(tsag_pkg::REG_LAYOUT_MODE, {17'($urandom), layout});
        cfg_write(tsag_pkg::REG_NEW_ORDER, {19'($urandom), order});
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [TB_COORD_BITS-1:0] pick_coord();
        case ($urandom_range(3))
            0:       return TB_COORD_BITS'($urandom_range(63));
            1:       return COORD_MAX - TB_COORD_BITS'($urandom_range(63));
            default: return TB_COORD_BITS'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [TB_STRIDE_BITS-1:0] stride;
        logic [TB_BPP_BITS-1:0]    bpp;
        logic [2:0]                layout;
        int                        mode;

        rst_n            = 1'b0;
        pixel_ch.valid   <= 1'b0;
        pixel_ch.pixel_x <= '0;
        pixel_ch.pixel_y <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= tsag_pkg::REG_ROW_STRIDE;
        cfg_ch.data      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults straight out of reset.
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(TB_COORD_BITS'(5), TB_COORD_BITS'(3));

        set_surface(STRIDE_MAX, TB_BPP_BITS'(16), tsag_pkg::LAYOUT_LINEAR, 1'b0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(TB_COORD_BITS'(0), TB_COORD_BITS'(0));
        set_surface(STRIDE_MAX, TB_BPP_BITS'(1), tsag_pkg::LAYOUT_MINOR_2X2, 1'b0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(TB_COORD_BITS'(1), TB_COORD_BITS'(1));
        set_surface(TB_STRIDE_BITS'(0), TB_BPP_BITS'(16), tsag_pkg::LAYOUT_TILED, 1'b1);
        send_pixel(COORD_MAX, TB_COORD_BITS'(0));
        send_pixel(TB_COORD_BITS'(3), COORD_MAX);
        set_surface(STRIDE_MAX, TB_BPP_BITS'(16), tsag_pkg::LAYOUT_SPLIT_TILED, 1'b0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(TB_COORD_BITS'(4), TB_COORD_BITS'(0));
        send_pixel(TB_COORD_BITS'(0), TB_COORD_BITS'(4));
        set_surface(STRIDE_MAX, TB_BPP_BITS'(16), tsag_pkg::LAYOUT_SPLIT_SUPERTILE, 1'b0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(TB_COORD_BITS'(8), TB_COORD_BITS'(4));
        send_pixel(TB_COORD_BITS'(63), TB_COORD_BITS'(127));
        set_surface(STRIDE_MAX, TB_BPP_BITS'(16), tsag_pkg::LAYOUT_SUPERTILE, 1'b0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(TB_COORD_BITS'(8), TB_COORD_BITS'(4));
        set_surface(STRIDE_MAX, TB_BPP_BITS'(16), tsag_pkg::LAYOUT_SUPERTILE, 1'b1);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(TB_COORD_BITS'(37), TB_COORD_BITS'(22));
        // Zero bytes per pixel leaves only the stride terms.
        set_surface(TB_STRIDE_BITS'(1000), TB_BPP_BITS'(0), LAYOUT_SPARE_A, 1'b1);
        send_pixel(TB_COORD_BITS'(100), TB_COORD_BITS'(200));
        set_surface(STRIDE_MAX, TB_BPP_BITS'(31), LAYOUT_SPARE_B, 1'b0);
        send_pixel(COORD_MAX, COORD_MAX);
        set_surface(TB_STRIDE_BITS'(1), TB_BPP_BITS'(17), tsag_pkg::LAYOUT_LINEAR, 1'b0);
        send_pixel(TB_COORD_BITS'(7), TB_COORD_BITS'(9));

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            mode = ph * 3 / RANDOM_PHASES;
            case ($urandom_range(3))
                0:       stride = '0;
                1:       stride = STRIDE_MAX;
                2:       stride = TB_STRIDE_BITS'($urandom_range(4095));
                default: stride = TB_STRIDE_BITS'($urandom);
            endcase
            if ($urandom_range(9) == 0)
                bpp = $urandom_range(1) ? TB_BPP_BITS'(0)
                                        : TB_BPP_BITS'($urandom_range(31, 17));
            else
                bpp = TB_BPP_BITS'($urandom_range(16, 1));
            layout = 3'($urandom_range(7));
            if (layout > tsag_pkg::LAYOUT_SUPERTILE && $urandom_range(1))
                layout = 3'($urandom_range(5));
            set_surface(stride, bpp, layout, 1'($urandom));
            if (mode == 0)
            begin
                sender_idle_pct   = 33;
                receiver_idle_pct = 73;
            end
            else if (mode == 1)
            begin
                sender_idle_pct   = 73;
                receiver_idle_pct = 33;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            if (ph == PRESSURE_PHASE)
                hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_pixel(pick_coord(), pick_coord());
        end

        wait_drained();
        if (tracker.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
src/tsag_pkg.sv
src/tsag_ifs.sv
src/tsag_cfg_regs.sv
src/tsag_decode.sv
src/tsag_mult.sv
src/tsag_sum.sv
src/tiled_surface_address_gen.sv
tb/tiled_surface_address_gen_tb.sv
